FILE: rtl/core/assert_macros.svh
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/l2mac_pkg.sv
package l2mac_pkg;
  localparam int MAC_W = 48;
  localparam int PORT_W = 5;
  localparam int STAMP_W = 32;
  localparam int MASK_W = 16;
  localparam int AGE_W = 16;
  localparam int REM_W = 7;
  localparam logic [MAC_W-1:0] BCAST_MAC = '1;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] DEC_BCAST   = 3'd0;
  localparam logic [2:0] DEC_FORWARD = 3'd1;
  localparam logic [2:0] DEC_FILTER  = 3'd2;
  localparam logic [2:0] DEC_UNKNOWN = 3'd3;
  localparam logic [2:0] DEC_DONE    = 3'd4;

  localparam logic [2:0] LRN_NONE    = 3'd0;
  localparam logic [2:0] LRN_NEW     = 3'd1;
  localparam logic [2:0] LRN_MOVED   = 3'd2;
  localparam logic [2:0] LRN_REFRESH = 3'd3;
  localparam logic [2:0] LRN_FULL    = 3'd4;

  localparam logic CFG_PORT_COUNT = 1'b0;
  localparam logic CFG_AGE_LIMIT  = 1'b1;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [MAC_W-1:0]  src_addr;
    logic [MAC_W-1:0]  dst_addr;
    logic [PORT_W-1:0] ingress_port;
  } req_t;

  typedef struct packed {
    logic [2:0]        decision;
    logic [PORT_W-1:0] egress_port;
    logic [MASK_W-1:0] flood_mask;
    logic [2:0]        learn_result;
    logic [REM_W-1:0]  removed_count;
  } rsp_t;
endpackage

FILE: rtl/core/l2_mac_learning_forwarder.sv
// MAC learning table with aging. Frames, ticks, sweeps and clears enter by
// push/full; each gives one result by empty/pop, in order. A frame or sweep
// scans all TABLE_DEPTH entries before its result: one entry is read per
// cycle from the table RAM, source and destination matched in the same pass,
// then, for a frame, the learn write. Tick and clear skip the scan. The
// back end starts a transaction only once the previous result has been
// popped. A two-deep path (front register, back) lets input be accepted while
// a result waits. No clearing pass is needed after reset.
module l2_mac_learning_forwarder #(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_PORTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  l2mac_pkg::req_t req,
  output logic            empty,
  input  logic            pop,
  output l2mac_pkg::rsp_t rsp,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);
  import l2mac_pkg::*;

  logic [PORT_W-1:0] port_count;
  logic [AGE_W-1:0] age_limit;
  logic q_valid, q_ready, q_bcast;
  req_t q_req;
  logic [MASK_W-1:0] q_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_count <= PORT_W'(4);
      age_limit <= AGE_W'(300);
    end else if (cfg_we) begin
      if (cfg_index == CFG_PORT_COUNT) port_count <= cfg_data[PORT_W-1:0];
      else age_limit <= cfg_data;
    end
  end

  l2mac_front #(.MAX_PORTS(MAX_PORTS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .port_count(port_count), .q_ready(q_ready), .q_valid(q_valid),
    .q_req(q_req), .q_bcast(q_bcast), .q_mask(q_mask)
  );

  l2mac_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready),
    .q_req(q_req), .q_bcast(q_bcast), .q_mask(q_mask),
    .age_limit(age_limit), .empty(empty), .pop(pop), .rsp(rsp)
  );
endmodule

FILE: rtl/core/l2mac_ram.sv
module l2mac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/l2mac_front.sv
module l2mac_front #(
  parameter int MAX_PORTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  l2mac_pkg::req_t            req,
  input  logic [l2mac_pkg::PORT_W-1:0] port_count,
  input  logic                       q_ready,
  output logic                       q_valid,
  output l2mac_pkg::req_t            q_req,
  output logic                       q_bcast,
  output logic [l2mac_pkg::MASK_W-1:0] q_mask
);
  import l2mac_pkg::*;

  logic [MASK_W-1:0] mask;
  logic [6:0] lim;

  always_comb begin
    lim = (7'(port_count) > 7'(MAX_PORTS)) ? 7'(MAX_PORTS) : 7'(port_count);
    mask = '0;
    for (int p = 1; p <= MASK_W; p++) begin
      if (7'(p) <= lim && 5'(p) != req.ingress_port) mask[p-1] = 1'b1;
    end
  end

  assign full = q_valid && !q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!full) begin
      q_valid <= push;
      if (push) begin
        q_req <= req;
        q_bcast <= (req.dst_addr == BCAST_MAC);
        q_mask <= mask;
      end
    end
  end
endmodule

FILE: rtl/core/l2mac_back.sv
module l2mac_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  l2mac_pkg::req_t              q_req,
  input  logic                         q_bcast,
  input  logic [l2mac_pkg::MASK_W-1:0] q_mask,
  input  logic [l2mac_pkg::AGE_W-1:0]  age_limit,
  output logic                         empty,
  input  logic                         pop,
  output l2mac_pkg::rsp_t              rsp
);
  import l2mac_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int ENT_W = MAC_W + PORT_W + STAMP_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_WRITE, S_DONE} state_t;
  state_t state;

  req_t cur_req;
  logic cur_bcast;
  logic [MASK_W-1:0] cur_mask;
  logic [TABLE_DEPTH-1:0] valid;
  logic [STAMP_W-1:0] now_ticks;
  logic [AW:0] cnt;
  logic [AW-1:0] cmp_idx;
  logic cmp_live;
  logic src_hit, dst_hit, free_hit;
  logic [AW-1:0] src_idx, free_idx;
  logic [PORT_W-1:0] src_port, dst_port;
  logic [REM_W-1:0] removed;

  logic we;
  logic [AW-1:0] waddr;
  logic [ENT_W-1:0] wdata, rdata;
  logic [MAC_W-1:0] r_mac;
  logic [PORT_W-1:0] r_port;
  logic [STAMP_W-1:0] r_stamp;
  logic [STAMP_W-1:0] age;

  assign {r_mac, r_port, r_stamp} = rdata;
  assign age = now_ticks - r_stamp;

  l2mac_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(cnt[AW-1:0]), .rdata(rdata)
  );

  assign q_ready = (state == S_IDLE) && empty;

  always_comb begin
    we = (state == S_WRITE) && (cur_req.opcode == OP_FRAME) && (src_hit || free_hit);
    waddr = src_hit ? src_idx : free_idx;
    wdata = {cur_req.src_addr, cur_req.ingress_port, now_ticks};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      now_ticks <= '0;
      empty <= 1'b1;
      cmp_live <= 1'b0;
    end else begin
      if (!empty && pop) empty <= 1'b1;
      cmp_live <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && empty) begin
            cur_req <= q_req;
            cur_bcast <= q_bcast;
            cur_mask <= q_mask;
            cnt <= '0;
            src_hit <= 1'b0;
            dst_hit <= 1'b0;
            free_hit <= 1'b0;
            removed <= '0;
            unique case (q_req.opcode)
              OP_FRAME, OP_SWEEP: state <= S_SCAN;
              OP_TICK: begin
                now_ticks <= now_ticks + 1'b1;
                state <= S_DONE;
              end
              default: begin
                valid <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          cmp_live <= 1'b1;
          cmp_idx <= cnt[AW-1:0];
          if (cnt == (AW+1)'(TABLE_DEPTH - 1)) state <= S_LAST;
        end
        S_LAST: state <= S_WRITE;
        S_WRITE: begin
          if (cur_req.opcode == OP_FRAME) begin
            if (!src_hit && free_hit) valid[free_idx] <= 1'b1;
            if (!src_hit && !dst_hit && !cur_bcast && free_hit
                && cur_req.dst_addr == cur_req.src_addr) begin
              dst_hit <= 1'b1;
              dst_port <= cur_req.ingress_port;
            end else if (src_hit && cur_req.dst_addr == cur_req.src_addr) begin
              dst_port <= cur_req.ingress_port;
            end
          end
          state <= S_DONE;
        end
        default: begin
          rsp.removed_count <= '0;
          rsp.egress_port <= '0;
          rsp.flood_mask <= '0;
          rsp.learn_result <= LRN_NONE;
          rsp.decision <= DEC_DONE;
          if (cur_req.opcode == OP_SWEEP) rsp.removed_count <= removed;
          if (cur_req.opcode == OP_FRAME) begin
            if (src_hit) rsp.learn_result <= (src_port != cur_req.ingress_port)
                                             ? LRN_MOVED : LRN_REFRESH;
            else if (free_hit) rsp.learn_result <= LRN_NEW;
            else rsp.learn_result <= LRN_FULL;
            if (cur_bcast) begin
              rsp.decision <= DEC_BCAST;
              rsp.flood_mask <= cur_mask;
            end else if (dst_hit) begin
              if (dst_port == cur_req.ingress_port) begin
                rsp.decision <= DEC_FILTER;
              end else begin
                rsp.decision <= DEC_FORWARD;
                rsp.egress_port <= dst_port;
              end
            end else begin
              rsp.decision <= DEC_UNKNOWN;
              rsp.flood_mask <= cur_mask;
            end
          end
          empty <= 1'b0;
          state <= S_IDLE;
        end
      endcase
      if (cmp_live) begin
        if (valid[cmp_idx]) begin
          if (cur_req.opcode == OP_SWEEP) begin
            if (age_limit != '0 && age > STAMP_W'(age_limit)) begin
              valid[cmp_idx] <= 1'b0;
              removed <= removed + 1'b1;
            end
          end else begin
            if (!src_hit && r_mac == cur_req.src_addr) begin
              src_hit <= 1'b1;
              src_idx <= cmp_idx;
              src_port <= r_port;
            end
            if (!dst_hit && r_mac == cur_req.dst_addr) begin
              dst_hit <= 1'b1;
              dst_port <= r_port;
            end
          end
        end else if (!free_hit) begin
          free_hit <= 1'b1;
          free_idx <= cmp_idx;
        end
      end
    end
  end

  `ASSERT_IMP(a_ready_idle, clk, rst, q_ready, state == S_IDLE && empty)
  `ASSERT_NEXT(a_done_shows, clk, rst, state == S_DONE, !empty && state == S_IDLE)
  `ASSERT_IMP(a_write_frame, clk, rst, we, cur_req.opcode == OP_FRAME)
  `ASSERT_IMP(a_cmp_scan, clk, rst, cmp_live, state == S_SCAN || state == S_LAST)
endmodule

FILE: tb/tb_top.sv
module tb_top;
  import l2mac_pkg::*;

  class mac_table_predictor;
    bit              slot_used [64];
    bit [MAC_W-1:0]  slot_mac [64];
    bit [PORT_W-1:0] slot_port [64];
    bit [31:0]       slot_stamp [64];
    bit [31:0]       ticks;
    bit [4:0]        port_count;
    bit [15:0]       age_limit;
    rsp_t            pending_decisions [$];
    int              mismatches;
    int              popped;

    function void reset_state();
      foreach (slot_used[i]) slot_used[i] = 0;
      ticks = 0;
      port_count = 4;
      age_limit = 300;
    endfunction

    function void write_reg(bit idx, bit [15:0] val);
      if (idx == CFG_PORT_COUNT) port_count = val[4:0];
      else age_limit = val;
    endfunction

    function int lookup(bit [MAC_W-1:0] addr);
      for (int i = 0; i < 64; i++)
        if (slot_used[i] && slot_mac[i] == addr) return i;
      return -1;
    endfunction

    function bit [15:0] flood(bit [PORT_W-1:0] ingress);
      bit [15:0] m;
      int n;
      m = '0;
      n = (port_count > 16) ? 16 : port_count;
      for (int p = 1; p <= n; p++)
        if (p != ingress) m[p-1] = 1'b1;
      return m;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int s, d, freei;
      bit [31:0] age;
      e = '0;
      e.decision = DEC_DONE;
      case (r.opcode)
        OP_FRAME: begin
          s = lookup(r.src_addr);
          if (s >= 0) begin
            if (slot_port[s] != r.ingress_port) begin
              slot_port[s] = r.ingress_port;
              e.learn_result = LRN_MOVED;
            end else begin
              e.learn_result = LRN_REFRESH;
            end
            slot_stamp[s] = ticks;
          end else begin
            freei = -1;
            for (int i = 0; i < 64; i++)
              if (!slot_used[i] && freei < 0) freei = i;
            if (freei < 0) begin
              e.learn_result = LRN_FULL;
            end else begin
              slot_used[freei] = 1;
              slot_mac[freei] = r.src_addr;
              slot_port[freei] = r.ingress_port;
              slot_stamp[freei] = ticks;
              e.learn_result = LRN_NEW;
            end
          end
          if (r.dst_addr == BCAST_MAC) begin
            e.decision = DEC_BCAST;
            e.flood_mask = flood(r.ingress_port);
          end else begin
            d = lookup(r.dst_addr);
            if (d < 0) begin
              e.decision = DEC_UNKNOWN;
              e.flood_mask = flood(r.ingress_port);
            end else if (slot_port[d] == r.ingress_port) begin
              e.decision = DEC_FILTER;
            end else begin
              e.decision = DEC_FORWARD;
              e.egress_port = slot_port[d];
            end
          end
        end
        OP_TICK: ticks = ticks + 1;
        OP_SWEEP: begin
          if (age_limit != 0)
            for (int i = 0; i < 64; i++) begin
              age = ticks - slot_stamp[i];
              if (slot_used[i] && age > age_limit) begin
                slot_used[i] = 0;
                e.removed_count = e.removed_count + 1'b1;
              end
            end
        end
        default: foreach (slot_used[i]) slot_used[i] = 0;
      endcase
      pending_decisions.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      popped++;
      if (pending_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
        return;
      end
      e = pending_decisions.pop_front();
      if (got.decision != e.decision || got.egress_port != e.egress_port ||
          got.flood_mask != e.flood_mask || got.learn_result != e.learn_result ||
          got.removed_count != e.removed_count) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic clk, rst, push, full, empty, pop, cfg_we, cfg_index;
  logic [15:0] cfg_data;
  req_t req;
  rsp_t rsp;
  mac_table_predictor table_model;
  bit quiet;
  bit [MAC_W-1:0] mac_pool [80];
  int hold, long_done;

  l2_mac_learning_forwarder dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      pop = 0;
    end else if (hold > 0) begin
      pop = 0;
      hold--;
    end else if (!quiet && !long_done && table_model.popped >= 300) begin
      long_done = 1;
      hold = 600;
      pop = 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold = $urandom_range(1, 16) - 1;
      pop = 0;
    end else begin
      pop = 1;
    end
  end

  always @(posedge clk)
    if (!rst && pop && !empty) table_model.check_response(rsp);

  task automatic send(req_t r);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      push = 0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    push = 1;
    req = r;
    do @(posedge clk); while (full);
    table_model.note_request(r);
    @(negedge clk);
  endtask

  task automatic settle_and_write(bit idx, bit [15:0] val);
    push = 0;
    while (table_model.pending_decisions.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    table_model.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic req_t frame(bit [MAC_W-1:0] s, bit [MAC_W-1:0] d, bit [4:0] p);
    req_t r;
    r.opcode = OP_FRAME;
    r.src_addr = s;
    r.dst_addr = d;
    r.ingress_port = p;
    return r;
  endfunction

  function automatic req_t pick_item();
    req_t r;
    logic [127:0] raw;
    int k;
    raw = {$urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    k = $urandom_range(0, 99);
    if (k < 9) r.opcode = OP_TICK;
    else if (k < 15) r.opcode = OP_SWEEP;
    else if (k < 16) r.opcode = OP_CLEAR;
    else begin
      r.opcode = OP_FRAME;
      if ($urandom_range(0, 19) != 0) r.src_addr = mac_pool[$urandom_range(0, 79)];
      k = $urandom_range(0, 9);
      if (k == 0) r.dst_addr = BCAST_MAC;
      else if (k < 8) r.dst_addr = mac_pool[$urandom_range(0, 79)];
      if ($urandom_range(0, 19) != 0) r.ingress_port = 5'($urandom_range(1, 16));
    end
    return r;
  endfunction

  initial begin
    req_t t;
    bit [4:0] pcs [7];
    bit [15:0] ages [7];
    pcs = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd16, 5'd5};
    ages = '{16'd4, 16'd0, 16'd65535, 16'd2, 16'd1, 16'd30, 16'd3};
    table_model = new();
    table_model.reset_state();
    quiet = 0;
    hold = 0;
    long_done = 0;
    rst = 1;
    push = 0;
    pop = 0;
    req = '0;
    cfg_we = 0;
    cfg_index = CFG_PORT_COUNT;
    cfg_data = '0;
    foreach (mac_pool[i]) mac_pool[i] = MAC_W'({$urandom, $urandom});
    mac_pool[0] = '0;
    mac_pool[1] = BCAST_MAC;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send(frame(48'h0000_0000_0001, 48'h0, 5'd1));
    send(frame(48'h0, 48'h0000_0000_0001, 5'd2));
    send(frame(48'h0000_0000_0001, 48'h0, 5'd1));
    send(frame(48'h0000_0000_0001, 48'h0, 5'd3));
    send(frame(48'h0, 48'h0, 5'd2));
    send(frame(BCAST_MAC, BCAST_MAC, 5'd4));
    send(frame(48'h0000_0000_0002, BCAST_MAC, 5'd1));
    send(frame(48'haaaa_5555_aaaa, 48'h5555_aaaa_5555, 5'd0));
    send(frame(48'h5555_aaaa_5555, 48'haaaa_5555_aaaa, 5'd31));
    send(frame(48'h0000_0000_0003, BCAST_MAC, 5'd16));
    t = '0;
    t.opcode = OP_TICK;
    repeat (3) send(t);
    t.opcode = OP_SWEEP;
    send(t);
    t.opcode = OP_CLEAR;
    send(t);
    send(frame(48'h0000_0000_0001, 48'h0, 5'd1));

    for (int ph = 0; ph < 7; ph++) begin
      settle_and_write(CFG_PORT_COUNT, {11'd0, pcs[ph]});
      settle_and_write(CFG_AGE_LIMIT, ages[ph]);
      if (ph == 6) quiet = 1;
      repeat (175) send(pick_item());
    end
    push = 0;
    while (table_model.pending_decisions.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (table_model.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
